>>> hdl/tbos_pkg.sv
// ----------------------------------------------------------------------------
// tbos_pkg
// Types, field widths and constants for the tap beat offset statistics unit.
// ----------------------------------------------------------------------------
package tbos_pkg;

	// field widths
	localparam int PERIOD_W  = 11;
	localparam int FIRST_W   = 14;
	localparam int MINB_W    = 8;
	localparam int WIN_W     = 8;
	localparam int POS_W     = 20;
	localparam int AGE_W     = 10;
	localparam int OFS_W     = 11;
	localparam int CNTO_W    = 5;
	localparam int MEAN_W    = 9;
	localparam int DEV_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 14;

	// internal widths
	localparam int SMP_W     = 9;
	localparam int BEAT_W    = 12;
	localparam int D_W       = 22;
	localparam int KM_W      = 21;
	localparam int DV_W      = 24;
	localparam int REM_W     = 11;
	localparam int STEP_W    = 5;
	localparam int CS_W      = 20;
	localparam int SUM_W     = 16;
	localparam int SQ_W      = 24;
	localparam int PROD_W    = 19;
	localparam int DIFF_W    = 10;
	localparam int RT_W      = 20;

	localparam int AGE_LIMIT = 200;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 11'd500;
	localparam logic [FIRST_W-1:0]  FIRST_RST  = 14'd1000;
	localparam logic [MINB_W-1:0]   MINB_RST   = 8'd4;
	localparam logic [WIN_W-1:0]    WIN_RST    = 8'd100;
	localparam logic [BEAT_W-1:0]   BEAT_NONE  = 12'hFFF;
	localparam logic [RT_W-1:0]     SQRT_TOP   = 20'h40000;
	localparam logic [DEV_W-1:0]    DEV_SAT    = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD = 3'd0,
		REG_FIRST  = 3'd1,
		REG_MINB   = 3'd2,
		REG_WIN    = 3'd3,
		REG_AUDIO  = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_TAP     = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_TDIV,
		ST_ROUND,
		ST_CHECK,
		ST_SUM,
		ST_MDIV,
		ST_MEAN,
		ST_SQ,
		ST_VDIV,
		ST_SQRT,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		CS_DIV,
		CS_ROUND,
		CS_SQRT
	} cs_sel_t;

endpackage

>>> hdl/tbos_ram.sv
// ----------------------------------------------------------------------------
// tbos_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tbos_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 20
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/tbos_csub.sv
// ----------------------------------------------------------------------------
// tbos_csub
// Shared compare and subtract unit: reports a >= b and gives a - b. Used for
// restoring division steps, offset rounding and integer square root steps.
// ----------------------------------------------------------------------------
module tbos_csub #(
	parameter int W = 20
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	logic [W:0] ext_diff;

	assign ext_diff = {1'b0, a} - {1'b0, b};
	assign ge       = ~ext_diff[W];
	assign diff     = ext_diff[W-1:0];

endmodule

>>> hdl/tap_beat_offset_statistics_unit.sv
// ----------------------------------------------------------------------------
// tap_beat_offset_statistics_unit
// Matches tap events to a beat grid, collects accepted offsets and reports
// their truncated mean and floored standard deviation.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_ready is high only while the sequencer is
// idle, and a finished result sits in the output register so the next item can
// be taken while it waits. A restart, or a tap that is ignored, goes from idle
// straight to the output load. A tap runs a prepare step, a 24-step restoring
// division of the hit time by the beat period on the shared compare/subtract
// unit, one rounding step, one check step and the output load. The tap that
// fills the sample store goes on with two passes over the sample RAM (sum, then
// squared deviations), two more 24-step divisions by the count and a 10-step
// integer square root, all on the same compare/subtract unit.
module tap_beat_offset_statistics_unit import tbos_pkg::*; #(
	parameter int SAMPLE_COUNT = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [POS_W-1:0]     position_ms,
	input  logic [AGE_W-1:0]     event_age_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 accepted,
	output logic [OFS_W-1:0]     offset_ms,
	output logic [CNTO_W-1:0]    sample_count,
	output logic                 result_valid,
	output logic [MEAN_W-1:0]    mean_ms,
	output logic [DEV_W-1:0]     stddev_ms
);

	localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
	localparam int AW    = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

	// configuration
	logic [PERIOD_W-1:0] period_q;
	logic [FIRST_W-1:0]  first_q;
	logic [MINB_W-1:0]   minb_q;
	logic [WIN_W-1:0]    win_q;
	logic                audio_q;
	logic [PERIOD_W-1:0] p_eff;

	// sequencer and run state
	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [BEAT_W-1:0]   last_q;
	logic                done_q;
	logic [MEAN_W-1:0]   mean_q;
	logic [DEV_W-1:0]    dev_q;

	// per-item datapath
	logic                acc_q;
	logic signed [OFS_W-1:0] offset_q;
	logic [D_W-1:0]      d_q;
	logic                neg_q;
	logic [KM_W-1:0]     kmag_q;
	logic [DV_W-1:0]     div_q;
	logic [REM_W-1:0]    rem_q;
	logic [REM_W-1:0]    dvsr_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    idx_q;
	logic                vld_s1;
	logic                vld_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]     sq_q;
	logic [RT_W-1:0]     x_q;
	logic [RT_W-1:0]     rt_q;
	logic [RT_W-1:0]     bit_q;

	// output register
	logic                out_valid_q;
	logic                accepted_q;
	logic [OFS_W-1:0]    offset_out_q;
	logic [CNTO_W-1:0]   count_out_q;
	logic                result_valid_q;
	logic [MEAN_W-1:0]   mean_out_q;
	logic [DEV_W-1:0]    dev_out_q;

	// control decoded from state
	cs_sel_t             cs_sel;
	logic                ram_we;
	logic                rd_issue;
	logic                out_load;
	logic                div_step;

	logic                in_acc;
	logic [7:0]          age_sat;
	logic [D_W-1:0]      d_next;
	logic [D_W-1:0]      d_mag;
	logic                div_last;
	logic                take;
	logic                k_ge_min;
	logic [BEAT_W-1:0]   k12;
	logic [OFS_W-1:0]    ofs_abs;
	logic signed [OFS_W-1:0] om;
	logic [SUM_W-1:0]    sum_mag;
	logic                pass_end_sum;
	logic                pass_end_sq;

	logic [CS_W-1:0]     cs_a, cs_b, cs_diff;
	logic                cs_ge;
	logic [SMP_W-1:0]    ram_rdata;
	logic signed [DIFF_W-1:0]   dev_s1;
	logic signed [2*DIFF_W-1:0] sqr_s1;

	// configuration write port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			first_q  <= FIRST_RST;
			minb_q   <= MINB_RST;
			win_q    <= WIN_RST;
			audio_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				REG_FIRST:  first_q  <= cfg_data[FIRST_W-1:0];
				REG_MINB:   minb_q   <= cfg_data[MINB_W-1:0];
				REG_WIN:    win_q    <= cfg_data[WIN_W-1:0];
				REG_AUDIO:  audio_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign p_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

	// shared compare/subtract unit
	always_comb begin
		case (cs_sel)
			CS_ROUND: begin
				cs_a = CS_W'({rem_q, 1'b0});
				cs_b = CS_W'(dvsr_q);
			end
			CS_SQRT: begin
				cs_a = x_q;
				cs_b = rt_q + bit_q;
			end
			default: begin
				cs_a = CS_W'({rem_q, div_q[DV_W-1]});
				cs_b = CS_W'(dvsr_q);
			end
		endcase
	end

	tbos_csub #(.W(CS_W)) u_csub (
		.a    (cs_a),
		.b    (cs_b),
		.ge   (cs_ge),
		.diff (cs_diff)
	);

	tbos_ram #(.WIDTH(SMP_W), .DEPTH(SAMPLE_COUNT)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (offset_q[SMP_W-1:0]),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// tap arithmetic
	assign in_acc   = in_valid && in_ready;
	assign age_sat  = (event_age_ms > AGE_W'(AGE_LIMIT)) ? 8'(AGE_LIMIT) : event_age_ms[7:0];
	assign d_next   = D_W'(position_ms) - D_W'(age_sat) - D_W'(first_q);
	assign d_mag    = d_q[D_W-1] ? (D_W'(0) - d_q) : d_q;
	assign div_last = (step_q == STEP_W'(DV_W - 1));

	// cs_ge in the rounding step means the remainder reached half a period
	assign om = cs_ge ? (OFS_W'(rem_q) - OFS_W'(dvsr_q)) : OFS_W'(rem_q);

	always_comb begin
		k_ge_min = (neg_q && (kmag_q != '0)) ? 1'b0 : (kmag_q >= KM_W'(minb_q));
		k12      = neg_q ? (BEAT_W'(0) - kmag_q[BEAT_W-1:0]) : kmag_q[BEAT_W-1:0];
		ofs_abs  = offset_q[OFS_W-1] ? (OFS_W'(0) - offset_q) : offset_q;
		take     = k_ge_min && (k12 != last_q) && (ofs_abs <= OFS_W'(win_q)) &&
		           (cnt_q < CNT_W'(SAMPLE_COUNT));
	end

	assign sum_mag      = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
	assign pass_end_sum = (idx_q == cnt_q) && !vld_s1;
	assign pass_end_sq  = (idx_q == cnt_q) && !vld_s1 && !vld_s2;

	assign dev_s1 = $signed({ram_rdata[SMP_W-1], ram_rdata}) - $signed({mean_q[MEAN_W-1], mean_q});
	assign sqr_s1 = dev_s1 * dev_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (op == OP_RESTART || done_q || !audio_q) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_PREP;
					end
				end
			end
			ST_PREP:  state_d = ST_TDIV;
			ST_TDIV:  if (div_last) state_d = ST_ROUND;
			ST_ROUND: state_d = ST_CHECK;
			ST_CHECK: begin
				if (take && (cnt_q == CNT_W'(SAMPLE_COUNT - 1))) begin
					state_d = ST_SUM;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_SUM:   if (pass_end_sum) state_d = ST_MDIV;
			ST_MDIV:  if (div_last) state_d = ST_MEAN;
			ST_MEAN:  state_d = ST_SQ;
			ST_SQ:    if (pass_end_sq) state_d = ST_VDIV;
			ST_VDIV:  if (div_last) state_d = ST_SQRT;
			ST_SQRT:  if (bit_q[0]) state_d = ST_FIN;
			ST_FIN:   state_d = ST_OUT;
			ST_OUT:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		cs_sel   = CS_DIV;
		ram_we   = 1'b0;
		rd_issue = 1'b0;
		out_load = 1'b0;
		div_step = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_TDIV, ST_MDIV, ST_VDIV: div_step = 1'b1;
			ST_ROUND: cs_sel = CS_ROUND;
			ST_CHECK: ram_we = take;
			ST_SUM, ST_SQ: rd_issue = (idx_q != cnt_q);
			ST_SQRT:  cs_sel = CS_SQRT;
			ST_OUT:   out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= BEAT_NONE;
			done_q  <= 1'b0;
			mean_q  <= '0;
			dev_q   <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_issue;
			vld_s2  <= vld_s1 && (state_q == ST_SQ);
			if (in_acc && op == OP_RESTART) begin
				cnt_q  <= '0;
				last_q <= BEAT_NONE;
				done_q <= 1'b0;
				mean_q <= '0;
				dev_q  <= '0;
			end
			if (ram_we) begin
				cnt_q  <= cnt_q + CNT_W'(1);
				last_q <= k12;
			end
			if (state_q == ST_MDIV && div_last) begin
				// quotient shifts in on this same edge, so the mean is set in ST_MEAN
			end
			if (state_q == ST_MEAN) begin
				mean_q <= neg_q ? (MEAN_W'(0) - div_q[MEAN_W-1:0]) : div_q[MEAN_W-1:0];
			end
			if (state_q == ST_FIN) begin
				dev_q  <= (rt_q > RT_W'(DEV_SAT)) ? DEV_SAT : rt_q[DEV_W-1:0];
				done_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_q    <= 1'b0;
			offset_q <= '0;
			d_q      <= d_next;
		end
		if (state_q == ST_PREP) begin
			neg_q  <= d_q[D_W-1];
			div_q  <= DV_W'(d_mag);
			rem_q  <= '0;
			step_q <= '0;
			dvsr_q <= REM_W'(p_eff);
		end
		if (div_step) begin
			div_q  <= {div_q[DV_W-2:0], cs_ge};
			rem_q  <= cs_ge ? cs_diff[REM_W-1:0] : cs_a[REM_W-1:0];
			step_q <= step_q + STEP_W'(1);
		end
		if (state_q == ST_ROUND) begin
			kmag_q   <= div_q[KM_W-1:0] + KM_W'(cs_ge);
			offset_q <= neg_q ? (OFS_W'(0) - om) : om;
		end
		if (state_q == ST_CHECK) begin
			acc_q <= take;
			idx_q <= '0;
			sum_q <= '0;
		end
		if (rd_issue) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (state_q == ST_SUM) begin
			if (vld_s1) begin
				sum_q <= sum_q + SUM_W'($signed(ram_rdata));
			end
			if (pass_end_sum) begin
				neg_q  <= sum_q[SUM_W-1];
				div_q  <= DV_W'(sum_mag);
				rem_q  <= '0;
				step_q <= '0;
				dvsr_q <= REM_W'(cnt_q);
			end
		end
		if (state_q == ST_MEAN) begin
			idx_q <= '0;
			sq_q  <= '0;
		end
		prod_s2 <= sqr_s1[PROD_W-1:0];
		if (state_q == ST_SQ) begin
			if (vld_s2) begin
				sq_q <= sq_q + SQ_W'(prod_s2);
			end
			if (pass_end_sq) begin
				div_q  <= sq_q;
				rem_q  <= '0;
				step_q <= '0;
			end
		end
		if (state_q == ST_VDIV && div_last) begin
			// last quotient bit joins here; the root loop starts next cycle
			x_q   <= {div_q[RT_W-2:0], cs_ge};
			rt_q  <= '0;
			bit_q <= SQRT_TOP;
		end
		if (state_q == ST_SQRT) begin
			if (cs_ge) begin
				x_q  <= cs_diff;
				rt_q <= (rt_q >> 1) + bit_q;
			end else begin
				rt_q <= rt_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			accepted_q     <= acc_q;
			offset_out_q   <= offset_q;
			count_out_q    <= CNTO_W'(cnt_q);
			result_valid_q <= done_q;
			mean_out_q     <= done_q ? mean_q : '0;
			dev_out_q      <= done_q ? dev_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign offset_ms    = offset_out_q;
	assign sample_count = count_out_q;
	assign result_valid = result_valid_q;
	assign mean_ms      = mean_out_q;
	assign stddev_ms    = dev_out_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SAMPLE_COUNT))
		else $error("sample count past store depth");

	a_done_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == CNT_W'(SAMPLE_COUNT)))
		else $error("result flagged with store not full");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cnt_q < CNT_W'(SAMPLE_COUNT)) && !done_q)
		else $error("sample write with no room or after result");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rem_q < dvsr_q))
		else $error("division remainder not below divisor");

	a_stats_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_valid_q) |-> (mean_out_q == '0) && (dev_out_q == '0))
		else $error("statistics shown without result");

endmodule
